>>> rtl/srde_pkg.sv
// Package: shared types, constants and the hash function of the dictionary encoder.
`timescale 1ns / 1ps
package srde_pkg;

    localparam int unsigned DictDepthDef  = 1024;
    localparam int unsigned ValueWidthDef = 64;
    localparam int unsigned CodeW         = 30;
    localparam int unsigned ColW          = 16;
    localparam int unsigned StatusW       = 2;

    localparam logic [1:0] FmtInt32   = 2'd0;
    localparam logic [1:0] FmtFloat32 = 2'd1;

    localparam logic [StatusW-1:0] StOk       = 2'd0;
    localparam logic [StatusW-1:0] StFull     = 2'd1;
    localparam logic [StatusW-1:0] StOverflow = 2'd2;

    localparam logic [1:0] RegNumCols  = 2'd0;
    localparam logic [1:0] RegDrvMode  = 2'd1;
    localparam logic [1:0] RegComplex  = 2'd2;
    localparam logic [1:0] RegValueFmt = 2'd3;

    localparam logic [63:0] HashMul = 64'h9E3779B97F4A7C15;

    typedef enum logic [2:0] {
        t_idle,
        t_mul,
        t_hash,
        t_read,
        t_probe,
        t_code,
        t_emit,
        t_eor
    } t_state;

    // Result word as held in the output register.
    typedef struct packed {
        logic [CodeW-1:0]   code_word;
        logic               new_value;
        logic [63:0]        new_real;
        logic [63:0]        new_imag;
        logic [StatusW-1:0] status;
        logic               last;
    } t_result;

    // Hash before the slot reduction; the product term comes in precomputed.
    function automatic logic [63:0] hash_mix(input logic [63:0] r, input logic [63:0] i,
                                             input logic [63:0] i_prod);
        logic [63:0] h;
        h = r ^ (r >> 29) ^ i_prod ^ (i >> 31);
        h = h ^ (h >> 17);
        return h;
    endfunction

endpackage

>>> rtl/srde_dict_mem.sv
// Dictionary memory: key and id per slot, one read and one write port.
`timescale 1ns / 1ps
module srde_dict_mem #(
    parameter int unsigned DEPTH = srde_pkg::DictDepthDef,
    parameter int unsigned KW    = 128,
    parameter int unsigned IW    = 10
) (
    input  logic                     i_clk,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [KW-1:0]            o_rd_key,
    output logic [IW-1:0]            o_rd_id,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [KW-1:0]            i_wr_key,
    input  logic [IW-1:0]            i_wr_id
);
    logic [KW+IW-1:0] r_mem [DEPTH];
    logic [KW+IW-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_id, i_wr_key};
        end
        r_rd <= r_mem[i_rd_addr];
    end

    assign o_rd_key = r_rd[KW-1:0];
    assign o_rd_id  = r_rd[KW+IW-1:KW];
endmodule

>>> rtl/srde_used_mem.sv
// Slot occupancy memory, cleared by a pass over every slot after reset.
`timescale 1ns / 1ps
module srde_used_mem #(
    parameter int unsigned DEPTH = srde_pkg::DictDepthDef
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic                     o_rd_used,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    output logic                     o_busy
);
    localparam int unsigned AW = $clog2(DEPTH);

    // After reset, walk every slot once and clear it.
    logic          r_mem [DEPTH];
    logic          r_rd;
    logic          r_clr;
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr) begin
            if (r_clr_addr == AW'(DEPTH - 1)) r_clr <= 1'b0;
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            r_mem[r_clr_addr] <= 1'b0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= 1'b1;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    assign o_rd_used = r_rd;
    assign o_busy    = r_clr;
endmodule

>>> rtl/sparse_row_dictionary_encoder.sv
// Top level: sparse row dictionary encoder with hashed value dictionary.
//
//  channel | dir | fields (low bit first)
//  s_axis  | in  | tdata: real_bits[63:0], imag_bits[127:64]
//  m_axis  | out | tdata: code_word, new_value, new_real, new_imag, status
//          |     | tlast: last
//  cfg     | in  | i_cfg_we, i_cfg_idx, i_cfg_data
//
// A coded entry runs through mul, hash, read, probe, code and emit before the next
// accept, plus one probe step per extra slot of the linear-probe lookup; a row end
// adds the eor state and one output word. A zero entry in CSRV skips hash through emit.
// Result words wait in an output register; the next word is accepted after
// the last result of the current one is loaded.
// Reset is synchronous; afterwards a clearing pass over every slot voids the
// slot marks, and the input is held off until it ends.
// Stall on m_axis holds the result register and the sequencer.
`timescale 1ns / 1ps
module sparse_row_dictionary_encoder #(
    parameter int unsigned DICT_DEPTH  = srde_pkg::DictDepthDef,
    parameter int unsigned VALUE_WIDTH = srde_pkg::ValueWidthDef
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // real_bits[63:0], imag_bits[127:64]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // code_word[29:0], new_value[30], new_real[94:31], new_imag[158:95], status[160:159]
    output logic [167:0] m_axis_tdata,
    output logic         m_axis_tlast,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_data
);
    import srde_pkg::*;

    localparam int unsigned AW  = $clog2(DICT_DEPTH);
    localparam int unsigned CW  = $clog2(DICT_DEPTH + 1);
    localparam int unsigned KW  = 2 * VALUE_WIDTH;
    localparam int unsigned PW  = CW + ColW;
    localparam int unsigned VCW = (PW + 1 > CodeW) ? PW + 1 : CodeW;

    // configuration
    logic [ColW-1:0] r_num_cols;
    logic            r_drv, r_cplx;
    logic [1:0]      r_fmt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cols <= ColW'(1);
            r_drv      <= 1'b0;
            r_cplx     <= 1'b0;
            r_fmt      <= 2'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                RegNumCols:  r_num_cols <= i_cfg_data;
                RegDrvMode:  r_drv      <= i_cfg_data[0];
                RegComplex:  r_cplx     <= i_cfg_data[0];
                RegValueFmt: r_fmt      <= i_cfg_data[1:0];
                default:     r_num_cols <= r_num_cols;
            endcase
        end
    end

    // input decode: mask to format width, key signed zero as +0
    logic        w_narrow;
    logic [63:0] w_mask, w_raw_r, w_raw_i, w_key_r, w_key_i;
    logic        w_zr, w_zi;
    assign w_narrow = (r_fmt == FmtInt32) || (r_fmt == FmtFloat32);
    assign w_mask   = w_narrow ? 64'h0000_0000_FFFF_FFFF : ({64{1'b1}} >> (64 - VALUE_WIDTH));
    assign w_raw_r  = s_axis_tdata[63:0] & w_mask;
    assign w_raw_i  = r_cplx ? (s_axis_tdata[127:64] & w_mask) : 64'd0;
    always_comb begin
        priority case (r_fmt)
            FmtInt32: begin
                w_zr = (w_raw_r == 64'd0);
                w_zi = (w_raw_i == 64'd0);
            end
            FmtFloat32: begin
                w_zr = ((w_raw_r & ~(64'd1 << 31)) == 64'd0);
                w_zi = ((w_raw_i & ~(64'd1 << 31)) == 64'd0);
            end
            default: begin
                w_zr = ((w_raw_r & ~(64'd1 << 63)) == 64'd0);
                w_zi = ((w_raw_i & ~(64'd1 << 63)) == 64'd0);
            end
        endcase
    end
    assign w_key_r = w_zr ? 64'd0 : w_raw_r;
    assign w_key_i = w_zi ? 64'd0 : w_raw_i;

    // working registers
    t_state          r_state, n_state;
    logic [63:0]     r_key_r, r_key_i, r_raw_r, r_raw_i, r_prod;
    logic [31:0]     r_cross;
    logic            r_zero;
    logic [AW-1:0]   r_slot, n_slot;
    logic [AW:0]     r_probes;
    logic [CW-1:0]   r_count;
    logic [ColW-1:0] r_col;
    logic [CW-1:0]   r_id;
    logic            r_found_new, r_full;
    logic [PW-1:0]   r_mulres;
    t_result         r_out;
    logic            r_ovalid;

    logic [KW-1:0]   w_rd_key;
    logic [AW-1:0]   w_rd_id;
    logic            w_rd_used;
    logic            w_wr_en;
    logic [AW-1:0]   w_rd_addr;
    logic [ColW-1:0] w_cols;
    logic            w_row_end;
    logic            w_out_free;
    logic [KW-1:0]   w_key;
    logic            w_clr_busy;
    logic [63:0]     w_prod_lo;
    logic [31:0]     w_cross;

    assign w_cols     = (r_num_cols == '0) ? ColW'(1) : r_num_cols;
    assign w_row_end  = ({1'b0, r_col} + 17'd1) >= {1'b0, w_cols};
    assign w_out_free = !r_ovalid || m_axis_tready;
    assign w_key      = KW'({r_key_i[VALUE_WIDTH-1:0], r_key_r[VALUE_WIDTH-1:0]});

    // low 64 bits of the hash product from 32 by 32 partial products
    assign w_prod_lo = r_key_i[31:0] * HashMul[31:0];
    assign w_cross   = r_key_i[63:32] * HashMul[31:0] + r_key_i[31:0] * HashMul[63:32];

    srde_dict_mem #(.DEPTH(DICT_DEPTH), .KW(KW), .IW(AW)) u_dict (
        .i_clk     (i_clk),
        .i_rd_addr (w_rd_addr),
        .o_rd_key  (w_rd_key),
        .o_rd_id   (w_rd_id),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_slot),
        .i_wr_key  (w_key),
        .i_wr_id   (AW'(r_count))
    );

    srde_used_mem #(.DEPTH(DICT_DEPTH)) u_used (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (w_rd_addr),
        .o_rd_used (w_rd_used),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_slot),
        .o_busy    (w_clr_busy)
    );

    assign s_axis_tready = (r_state == t_idle) && !w_clr_busy && i_rst_n;

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_slot    = r_slot;
        w_wr_en   = 1'b0;
        w_rd_addr = r_slot;
        unique case (r_state)
            t_idle: if (s_axis_tvalid && s_axis_tready) n_state = t_mul;
            t_mul:  n_state = !r_zero ? t_hash : (w_row_end ? t_eor : t_idle);
            t_hash: begin
                n_slot  = AW'(hash_mix(r_key_r, r_key_i, r_prod + {r_cross, 32'd0})
                              % DICT_DEPTH);
                n_state = t_read;
            end
            t_read: n_state = t_probe;
            t_probe: begin
                if (!w_rd_used) begin
                    w_wr_en = (r_count < CW'(DICT_DEPTH));
                    n_state = t_code;
                end else if (w_rd_key == w_key) begin
                    n_state = t_code;
                end else if (r_probes == (AW+1)'(DICT_DEPTH - 1)) begin
                    n_state = t_code;
                end else begin
                    n_slot    = (r_slot == AW'(DICT_DEPTH - 1)) ? '0 : r_slot + AW'(1);
                    w_rd_addr = n_slot;
                    n_state   = t_probe;
                end
            end
            t_code: n_state = t_emit;
            t_emit: if (w_out_free) n_state = w_row_end ? t_eor : t_idle;
            t_eor:  if (w_out_free) n_state = t_idle;
            default: n_state = t_idle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= t_idle;
            r_count  <= '0;
            r_col    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_wr_en) r_count <= r_count + CW'(1);
            if ((r_state == t_emit && w_out_free) || (r_state == t_eor && w_out_free)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            // advance column when the entry leaves
            if ((r_state == t_emit && w_out_free) ||
                (r_state == t_eor && w_out_free)) begin
                if (r_state == t_emit && !w_row_end) r_col <= r_col + ColW'(1);
                else r_col <= '0;
            end else if (r_state == t_mul && r_zero && !w_row_end) begin
                // a zero entry in CSRV yields no word inside the row
                r_col <= r_col + ColW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        if (r_state == t_idle) begin
            r_key_r  <= w_key_r;
            r_key_i  <= w_key_i;
            r_raw_r  <= w_raw_r;
            r_raw_i  <= w_raw_i;
            r_zero   <= w_zr && w_zi && !r_drv;
            r_probes <= '0;
        end
        if (r_state == t_mul) begin
            r_prod  <= w_prod_lo;
            r_cross <= w_cross;
        end
        if (r_state == t_probe) begin
            r_probes <= r_probes + (AW+1)'(1);
            if (!w_rd_used) begin
                r_found_new <= (r_count < CW'(DICT_DEPTH));
                r_full      <= !(r_count < CW'(DICT_DEPTH));
                r_id        <= r_count;
            end else if (w_rd_key == w_key) begin
                r_found_new <= 1'b0;
                r_full      <= 1'b0;
                r_id        <= CW'(w_rd_id);
            end else begin
                r_found_new <= 1'b0;
                r_full      <= 1'b1;
            end
        end
        if (r_state == t_code) begin
            r_mulres <= PW'(r_id) * PW'(w_cols);
        end
        if (r_state == t_emit && w_out_free) begin
            logic [VCW-1:0] v_code;
            v_code = r_drv ? VCW'(r_id) + VCW'(1)
                           : VCW'(r_mulres) + VCW'(r_col) + VCW'(1);
            r_out.code_word <= r_full ? '0 : v_code[CodeW-1:0];
            r_out.new_value <= r_found_new;
            r_out.new_real  <= r_found_new ? r_raw_r : 64'd0;
            r_out.new_imag  <= r_found_new ? r_raw_i : 64'd0;
            r_out.status    <= r_full ? StFull :
                               ((v_code >> CodeW) != '0) ? StOverflow : StOk;
            r_out.last      <= !w_row_end;
        end else if (r_state == t_eor && w_out_free) begin
            r_out <= '{default: '0, last: 1'b1};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {7'd0, r_out.status, r_out.new_imag, r_out.new_real,
                            r_out.new_value, r_out.code_word};
    assign m_axis_tlast  = r_out.last;

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> r_state == t_idle) else $error("ready outside idle");
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DICT_DEPTH)) else $error("distinct count past depth");
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !m_axis_tready |=> r_ovalid) else $error("result dropped under stall");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !m_axis_tready |=> $stable(r_out)) else $error("result changed under stall");
    a_clear_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clr_busy |-> !s_axis_tready) else $error("input taken during clearing pass");
endmodule

>>> test/sparse_row_dictionary_encoder_tb.sv
// Testbench for the sparse row dictionary encoder: directed and random entries checked word by word.
`timescale 1ns / 1ps
module sparse_row_dictionary_encoder_tb;
    import srde_pkg::*;

    localparam int unsigned Depth     = 1024;
    localparam int unsigned Stall     = 20000;   // idle cycles before the run is declared hung
    localparam int unsigned DrainWait = 64;      // entries without a word may still be in flight
    localparam logic [63:0] CodeLimit = 64'd1 << 30;
    localparam logic [1:0]  FmtFloat64 = 2'd2;
    localparam logic [1:0]  FmtUnused  = 2'd3;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;   // real_bits[63:0], imag_bits[127:64]
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // code_word[29:0], new_value[30], new_real[94:31], new_imag[158:95], status[160:159]
    logic [167:0] m_axis_tdata;
    logic         m_axis_tlast;
    logic         i_cfg_we = 1'b0;
    logic [1:0]   i_cfg_idx = '0;
    logic [15:0]  i_cfg_data = '0;

    sparse_row_dictionary_encoder DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Shadow of the block: registers, column counter and the value dictionary.
    logic [15:0] cols_reg = 16'd1;
    logic        drv_reg = 1'b0;
    logic        cplx_reg = 1'b0;
    logic [1:0]  fmt_reg = FmtFloat64;
    int unsigned col_pos = 0;
    int unsigned distinct = 0;
    int unsigned value_ids [logic [127:0]];

    t_result pending_words [$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned errors = 0;
    int unsigned entries_sent = 0;
    int unsigned words_checked = 0;
    int unsigned row_ends = 0;
    int unsigned full_hits = 0;
    int unsigned quiet_cycles = 0;

    logic [63:0] real_pool [24];
    logic [63:0] imag_pool [4];

    function automatic logic part_zero(input logic [63:0] v);
        case (fmt_reg)
            FmtInt32:   return v == 64'd0;
            FmtFloat32: return v[30:0] == 31'd0;
            default:    return v[62:0] == 63'd0;
        endcase
    endfunction

    // Work out the words one entry causes and queue them; advance the shadow state.
    task automatic encode_entry(input logic [63:0] re, input logic [63:0] im);
        logic [63:0] mask, raw_r, raw_i, key_r, key_i, code;
        logic        zr, zi;
        int unsigned cols, id;
        int unsigned n;
        t_result     w;
        n     = 0;
        mask  = (fmt_reg == FmtInt32 || fmt_reg == FmtFloat32) ? 64'hFFFF_FFFF : '1;
        raw_r = re & mask;
        raw_i = cplx_reg ? (im & mask) : 64'd0;
        zr    = part_zero(raw_r);
        zi    = part_zero(raw_i);
        key_r = zr ? 64'd0 : raw_r;
        key_i = zi ? 64'd0 : raw_i;
        cols  = (cols_reg == 16'd0) ? 1 : cols_reg;
        if (!(zr && zi) || drv_reg) begin
            w = '0;
            if (value_ids.exists({key_i, key_r})) begin
                id = value_ids[{key_i, key_r}];
            end else if (distinct < Depth) begin
                id = distinct;
                value_ids[{key_i, key_r}] = id;
                distinct++;
                w.new_value = 1'b1;
                w.new_real  = raw_r;
                w.new_imag  = raw_i;
            end else begin
                id = Depth;
            end
            if (id == Depth) begin
                w.status = StFull;
                full_hits++;
            end else begin
                code = drv_reg ? 64'(id) + 64'd1 : 64'(id) * 64'(cols) + 64'(col_pos) + 64'd1;
                w.code_word = code[CodeW-1:0];
                w.status    = (code >= CodeLimit) ? StOverflow : StOk;
            end
            pending_words.push_back(w);
            n++;
        end
        if (col_pos + 1 >= cols) begin
            col_pos = 0;
            pending_words.push_back('0);
            n++;
            row_ends++;
        end else begin
            col_pos++;
        end
        if (n > 0) pending_words[$].last = 1'b1;
    endtask

    // Drive one entry, hold it until taken, then predict its words.
    task automatic send_entry(input logic [63:0] re, input logic [63:0] im);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {im, re};
        do @(posedge i_clk); while (!s_axis_tready);
        encode_entry(re, im);
        entries_sent++;
    endtask

    // Drop valid and wait out every queued word plus the block's tail.
    task automatic drain(input int unsigned tail);
        s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            RegNumCols:  cols_reg = data;
            RegDrvMode:  drv_reg  = data[0];
            RegComplex:  cplx_reg = data[0];
            default:     fmt_reg  = data[1:0];
        endcase
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [15:0] cols, input logic drv, input logic cplx,
                             input logic [1:0] fmt);
        write_reg(RegNumCols, cols);
        write_reg(RegDrvMode, {15'd0, drv});
        write_reg(RegComplex, {15'd0, cplx});
        write_reg(RegValueFmt, {14'd0, fmt});
    endtask

    // Receiver: stall at random and compare each taken word with the oldest prediction.
    always @(posedge i_clk) begin
        t_result w;
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (m_axis_tvalid && m_axis_tready && i_rst_n) begin
            words_checked++;
            if (pending_words.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: data %h last %b", m_axis_tdata, m_axis_tlast);
            end else begin
                w = pending_words.pop_front();
                if (m_axis_tdata[29:0] !== w.code_word || m_axis_tdata[30] !== w.new_value ||
                    m_axis_tdata[94:31] !== w.new_real || m_axis_tdata[158:95] !== w.new_imag ||
                    m_axis_tdata[160:159] !== w.status || m_axis_tlast !== w.last) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch exp: code %0d new %b re %h im %h st %0d last %b",
                                 w.code_word, w.new_value, w.new_real, w.new_imag,
                                 w.status, w.last);
                        $display("         got: code %0d new %b re %h im %h st %0d last %b",
                                 m_axis_tdata[29:0], m_axis_tdata[30], m_axis_tdata[94:31],
                                 m_axis_tdata[158:95], m_axis_tdata[160:159], m_axis_tlast);
                    end
                end
            end
        end
    end

    // Watchdog: count cycles with no word moving on either side and no register write.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= Stall) begin
            $display("sparse_row_dictionary_encoder_tb NOT OK");
            $finish;
        end
    end

    // Extremes, signed zeros, NaN, masking of unused bits and every mode.
    task automatic test_directed();
        send_entry(64'd0, 64'd0);                       // zero in CSRV: row end only
        send_entry(64'h8000_0000_0000_0000, '1);        // float64 negative zero
        send_entry('1, '1);                             // all ones, a NaN pattern
        send_entry(64'h7FF8_0000_0000_0001, 64'd0);     // NaN by bit pattern
        send_entry('1, 64'd0);                          // repeat: known id
        drain(DrainWait);
        configure(16'd3, 1'b0, 1'b1, FmtInt32);
        send_entry(64'hFFFF_FFFF_0000_0000, 64'h1234_0000_0000_0000); // zero once masked
        send_entry(64'h0000_0000_8000_0000, 64'hABCD_0000_0000_0005);
        send_entry(64'd1, 64'hFFFF_FFFF_FFFF_FFFF);
        send_entry(64'hDEAD_BEEF_0000_0001, 64'h0000_0001_0000_0000); // imag zero in int32
        drain(DrainWait);
        configure(16'd4, 1'b1, 1'b1, FmtFloat32);
        send_entry(64'h0000_0000_8000_0000, 64'hFFFF_FFFF_8000_0000); // both float32 -0
        send_entry(64'd0, 64'h3F80_0000);
        send_entry(64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
        send_entry(64'd0, 64'd0);
        drain(DrainWait);
        configure(16'd0, 1'b0, 1'b0, FmtUnused);        // zero columns acts as one
        send_entry(64'h8000_0000_0000_0000, 64'd5);     // imag ignored: zero
        send_entry(64'h0000_0001_0000_0000, 64'd7);
        drain(DrainWait);
        configure(16'hFFFF, 1'b0, 1'b1, FmtFloat64);
        send_entry('1, '1);
        send_entry(64'h0000_0001_0000_0000, 64'h8000_0000_0000_0000);
        drain(DrainWait);
    endtask

    function automatic logic [63:0] pick_real();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 15) return {$urandom, $urandom} & 64'hFFFF_FFFF_8000_0000; // zero-like
        if (sel < 20) return {$urandom, $urandom};
        return real_pool[$urandom_range(23)];
    endfunction

    // Random entries under several settings; fresh values stay rare so the dictionary holds.
    task automatic test_random_rows(input int unsigned phases, input int unsigned per_phase);
        logic [15:0] cols;
        logic [63:0] im;
        for (int p = 0; p < phases; p++) begin
            case ($urandom_range(5))
                0: cols = 16'd1;
                1: cols = 16'd2;
                2: cols = 16'hFFFF;
                3: cols = 16'd0;
                default: cols = 16'($urandom_range(3, 9));
            endcase
            configure(cols, 1'($urandom), 1'($urandom), 2'($urandom));
            for (int k = 0; k < per_phase; k++) begin
                im = ($urandom_range(99) < 5) ? {$urandom, $urandom}
                                              : imag_pool[$urandom_range(3)];
                send_entry(pick_real(), im);
            end
            drain(DrainWait);
        end
    endtask

    // Fill the dictionary to the last slot, then overrun it in both coding modes.
    task automatic test_full_dictionary();
        logic [63:0] seed_val;
        configure(16'd1, 1'b0, 1'b0, FmtFloat64);
        seed_val = 64'h5A00_0000_0000_0000;
        while (distinct < Depth + 4) begin
            if (distinct >= Depth) begin
                send_entry(seed_val, 64'd0);
                seed_val++;
                if (full_hits >= 4) break;
            end else begin
                send_entry(seed_val, 64'd0);
                seed_val++;
            end
        end
        send_entry(real_pool[0], 64'd0);                 // known value still codes
        drain(Depth + DrainWait);
        configure(16'd2, 1'b1, 1'b1, FmtFloat64);
        send_entry(64'h1111_2222_3333_4444, 64'h5555_6666_7777_8888);
        send_entry(64'd0, 64'd0);
        drain(Depth + DrainWait);
    endtask

    initial begin
        for (int k = 0; k < 24; k++) real_pool[k] = {$urandom, $urandom};
        real_pool[0] = '1;
        imag_pool[0] = 64'd0;
        for (int k = 1; k < 4; k++) imag_pool[k] = {$urandom, $urandom};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        send_idle_pct = 10;
        recv_idle_pct = 46;
        test_random_rows(5, 40);
        send_idle_pct = 46;
        recv_idle_pct = 10;
        test_random_rows(5, 40);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_rows(5, 40);
        test_full_dictionary();

        $display("covered %0d entries, %0d words, %0d row ends, %0d distinct values",
                 entries_sent, words_checked, row_ends, distinct);
        $display("dictionary overrun hit %0d times, %0d mismatches", full_hits, errors);
        if (errors == 0 && pending_words.size() == 0)
            $display("sparse_row_dictionary_encoder_tb OK");
        else
            $display("sparse_row_dictionary_encoder_tb NOT OK");
        $finish;
    end

endmodule
